/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/mhrv_pkg.sv */
package mhrv_pkg;

   localparam int MHRV_WORD_W = 32;
   localparam int MHRV_DEPTH  = 64;

   localparam int MHRV_POS_W   = 6;
   localparam int MHRV_COUNT_W = 7;

   localparam logic [1:0] REQ_CLEAR   = 2'd0;
   localparam logic [1:0] REQ_APPEND  = 2'd1;
   localparam logic [1:0] REQ_REPLACE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

endpackage

/* hw/rtl/mhrv_ram.sv */
module mhrv_ram
   import mhrv_pkg::*;
#(
   parameter int WIDTH = MHRV_WORD_W,
   parameter int DEPTH = MHRV_DEPTH,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/min_heap_replace_value.sv */
// Binary min-heap of signed 32-bit values held in one single-port-read,
// single-port-write RAM with a registered read. Each request (clear,
// append, replace, or the unused type, which changes nothing) answers with
// one response transaction. Clear and append pass from acceptance through
// the emit state to the response register. A replace scans slots in order,
// one RAM read a cycle, then sifts: a level moved up reads the parent and
// compares; a level moved down reads the left child, then any right child;
// once a compare stops the sift, the value is written once in its final
// slot and the response is posted. The single RAM read port sets this pace.
// One request is in flight at a time; a new request is taken while the
// previous response still waits on rsp_tready.
// The RAM needs no clearing after reset: only slots below the count are used.
module min_heap_replace_value
   import mhrv_pkg::*;
#(
   parameter int HEAP_DEPTH = MHRV_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] old_value, [63:32] new_value
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [5:0] final_position, [12:6] entry_count,
                                    // [44:13] root_value, [47:45] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   `include "assert_macros.svh"

   localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int LW = AW + 2;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_SEARCH = 9'b000000010,
      S_UP     = 9'b000000100,
      S_UPCMP  = 9'b000001000,
      S_DOWN   = 9'b000010000,
      S_LEFT   = 9'b000100000,
      S_RIGHT  = 9'b001000000,
      S_PLACE  = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [AW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        count_ff, count_in;
   logic signed [31:0]   val_ff, val_in;
   logic signed [31:0]   old_ff, old_in;
   logic signed [31:0]   lval_ff, lval_in;
   logic signed [31:0]   root_ff;
   logic [1:0]           res_status_ff, res_status_in;
   logic [AW-1:0]        res_pos_ff, res_pos_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff;
   logic [MHRV_POS_W-1:0]   rsp_pos_ff;
   logic [MHRV_COUNT_W-1:0] rsp_count_ff;
   logic signed [31:0]   rsp_root_ff;
   logic                 rsp_load;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [31:0]          wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [31:0]          rd_data;
   logic signed [31:0]   rd_val;

   logic [AW-1:0]        parent;
   logic [LW-1:0]        left_w;
   logic [LW-1:0]        right_w;
   logic [LW-1:0]        count_w;
   logic [CW-1:0]        next_idx;
   logic                 right_pick;
   logic [AW-1:0]        child;
   logic signed [31:0]   cval;

   logic [AW+MHRV_POS_W-1:0]   pos_wide;
   logic [CW+MHRV_COUNT_W-1:0] count_wide;

   logic                 clear_acc;
   logic                 sift_busy;

   mhrv_ram #(
      .WIDTH (MHRV_WORD_W),
      .DEPTH (HEAP_DEPTH)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_val   = $signed(rd_data);
   assign parent   = (pos_ff - AW'(1)) >> 1;
   assign left_w   = LW'({pos_ff, 1'b1});
   assign right_w  = left_w + LW'(1);
   assign count_w  = LW'(count_ff);
   assign next_idx = CW'(pos_ff) + CW'(1);
   // equal children: the right one counts as the smaller
   assign right_pick = !(lval_ff < rd_val);
   assign child      = right_pick ? right_w[AW-1:0] : left_w[AW-1:0];
   assign cval       = right_pick ? rd_val : lval_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_load   = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      val_in        = val_ff;
      old_in        = old_ff;
      lval_in       = lval_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = val_ff;
      rd_en         = 1'b0;
      rd_addr       = pos_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               old_in        = $signed(req_tdata[31:0]);
               val_in        = $signed(req_tdata[63:32]);
               res_status_in = ST_OK;
               res_pos_in    = '0;
               state_in      = S_EMIT;
               case (req_tuser)
                  REQ_CLEAR: begin
                     count_in = '0;
                  end
                  REQ_APPEND: begin
                     if (count_ff == CW'(HEAP_DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        wr_addr    = count_ff[AW-1:0];
                        wr_data    = req_tdata[63:32];
                        res_pos_in = count_ff[AW-1:0];
                        count_in   = count_ff + CW'(1);
                     end
                  end
                  REQ_REPLACE: begin
                     if (count_ff == '0) begin
                        res_status_in = ST_NOT_FOUND;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        pos_in   = '0;
                        state_in = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEARCH: begin
            // read of the next slot overlaps the compare of this one
            rd_en   = 1'b1;
            rd_addr = pos_ff + AW'(1);
            if (rd_val == old_ff) begin
               state_in = S_UP;
            end else if (next_idx == count_ff) begin
               res_status_in = ST_NOT_FOUND;
               state_in      = S_EMIT;
            end else begin
               pos_in = pos_ff + AW'(1);
            end
         end
         S_UP: begin
            if (pos_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = parent;
               state_in = S_UPCMP;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_UPCMP: begin
            if (val_ff < rd_val) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               state_in = S_DOWN;
            end
         end
         S_DOWN: begin
            if (left_w >= count_w) begin
               state_in = S_PLACE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = left_w[AW-1:0];
               state_in = S_LEFT;
            end
         end
         S_LEFT: begin
            lval_in = rd_val;
            if (right_w < count_w) begin
               rd_en    = 1'b1;
               rd_addr  = right_w[AW-1:0];
               state_in = S_RIGHT;
            end else if (rd_val < val_ff) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               pos_in   = left_w[AW-1:0];
               // the parent now holds a smaller value, skip its check
               state_in = S_DOWN;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_RIGHT: begin
            if (cval < val_ff) begin
               wr_en    = 1'b1;
               wr_data  = cval;
               pos_in   = child;
               state_in = S_DOWN;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            // the moving value is written once, at the slot where it stops
            wr_en      = 1'b1;
            res_pos_in = pos_ff;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign pos_wide   = {{MHRV_POS_W{1'b0}}, res_pos_ff};
   assign count_wide = {{MHRV_COUNT_W{1'b0}}, count_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      old_ff        <= old_in;
      lval_ff       <= lval_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      // shadow copy of slot 0
      if (wr_en && (wr_addr == '0)) begin
         root_ff <= $signed(wr_data);
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_pos_ff    <= pos_wide[MHRV_POS_W-1:0];
         rsp_count_ff  <= count_wide[MHRV_COUNT_W-1:0];
         rsp_root_ff   <= (count_ff != '0) ? root_ff : 32'sd0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_root_ff, rsp_count_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign clear_acc = req_tvalid && req_tready && (req_tuser == REQ_CLEAR);
   assign sift_busy = !((state_ff == S_IDLE) || (state_ff == S_EMIT));

   `ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(HEAP_DEPTH), "heap count above depth")
   `ASSERT_ALWAYS(a_write_in_range, !wr_en || (CW'(wr_addr) <= count_ff), "write past heap end")
   `ASSERT_NEXT(a_clear_empties, clear_acc, count_ff == '0, "clear left entries")
   `ASSERT_ALWAYS(a_sift_has_entries, !sift_busy || (count_ff != '0), "sift on empty heap")

endmodule

/* sim/tb_min_heap_replace_value.sv */
`timescale 1ns / 100ps

module tb_min_heap_replace_value;
   import mhrv_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 200;
   localparam int RANDOM_ITEMS = 700;

   typedef struct packed {
      logic [1:0]                     status;
      logic [MHRV_POS_W-1:0]          pos;
      logic [MHRV_COUNT_W-1:0]        count;
      logic signed [MHRV_WORD_W-1:0]  root;
   } heap_result_t;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] oldv;
      logic signed [31:0] newv;
      bit                 typed;
      heap_result_t       want;
   } stim_row_t;

   localparam heap_result_t NO_RESULT = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [31:0] old_value, [63:32] new_value
   logic [1:0]  req_tuser = '0;   // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [5:0] final_position, [12:6] entry_count,
                                  // [44:13] root_value, [47:45] zero
   logic [1:0]  rsp_tuser;        // [1:0] status

   min_heap_replace_value dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("min_heap_replace_value test failed");
      $finish;
   end

   // mirror of the heap contents
   logic signed [31:0] heap_mirror [MHRV_DEPTH];
   int heap_size = 0;

   heap_result_t pending_results [$];
   int  items_sent = 0;
   int  fault_count = 0;
   bit  idle_off = 1'b0;
   bit  hold_req = 1'b0;

   function automatic heap_result_t heap_apply(input logic [1:0] kind,
                                               input logic signed [31:0] oldv,
                                               input logic signed [31:0] newv);
      heap_result_t r;
      int i, slot, up, left, child;
      bit hit, moved;
      logic signed [31:0] t;
      r = '0;
      r.status = ST_OK;
      case (kind)
         REQ_CLEAR: heap_size = 0;
         REQ_APPEND: begin
            if (heap_size >= MHRV_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               heap_mirror[heap_size] = newv;
               r.pos = heap_size[MHRV_POS_W-1:0];
               heap_size++;
            end
         end
         REQ_REPLACE: begin
            hit = 1'b0;
            slot = 0;
            for (i = 0; i < heap_size && !hit; i++) begin
               if (heap_mirror[i] == oldv) begin
                  hit = 1'b1;
                  slot = i;
               end
            end
            if (!hit) begin
               r.status = ST_NOT_FOUND;
            end else begin
               heap_mirror[slot] = newv;
               do begin
                  moved = 1'b0;
                  up = (slot - 1) / 2;
                  if (slot > 0 && heap_mirror[slot] < heap_mirror[up]) begin
                     t = heap_mirror[slot];
                     heap_mirror[slot] = heap_mirror[up];
                     heap_mirror[up] = t;
                     slot = up;
                     moved = 1'b1;
                  end else begin
                     left = 2 * slot + 1;
                     if (left < heap_size) begin
                        child = left;
                        // ties go to the right child
                        if (left + 1 < heap_size &&
                            !(heap_mirror[left] < heap_mirror[left + 1]))
                           child = left + 1;
                        if (heap_mirror[child] < heap_mirror[slot]) begin
                           t = heap_mirror[slot];
                           heap_mirror[slot] = heap_mirror[child];
                           heap_mirror[child] = t;
                           slot = child;
                           moved = 1'b1;
                        end
                     end
                  end
               end while (moved);
               r.pos = slot[MHRV_POS_W-1:0];
            end
         end
         default: ;
      endcase
      r.count = heap_size[MHRV_COUNT_W-1:0];
      r.root = (heap_size > 0) ? heap_mirror[0] : '0;
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_idle();
      int r;
      if (idle_off) return 0;
      r = $urandom_range(0, 9);
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [31:0] pick_value(input int mode);
      if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
      case (mode)
         0: return $urandom;
         1: return int'($urandom_range(0, 6)) - 3;
         default: return int'($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   task automatic offer_request(input logic [1:0] kind, input logic signed [31:0] oldv,
                                input logic signed [31:0] newv, input bit typed,
                                input heap_result_t want_typed);
      int gap;
      heap_result_t want;
      gap = pick_idle();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {newv, oldv};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      want = heap_apply(kind, oldv, newv);
      if (typed) want = want_typed;
      pending_results.push_back(want);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // response side: check, then decide ready for the next cycle
   initial begin : rsp_side
      heap_result_t want, got;
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.pos = rsp_tdata[5:0];
            got.count = rsp_tdata[12:6];
            got.root = rsp_tdata[44:13];
            if (pending_results.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected response transaction: status %0d pos %0d count %0d root %0d",
                           got.status, got.pos, got.count, got.root);
               fault_count++;
            end else begin
               want = pending_results.pop_front();
               if (got != want || rsp_tdata[47:45] != 3'b000) begin
                  if (fault_count < 10)
                     $display("mismatch: expected status %0d pos %0d count %0d root %0d, got status %0d pos %0d count %0d root %0d pad %0d",
                              want.status, want.pos, want.count, want.root,
                              got.status, got.pos, got.count, got.root, rsp_tdata[47:45]);
                  fault_count++;
               end
            end
         end
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = pick_idle();
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   stim_row_t directed_rows [25] = '{
      '{REQ_REPLACE, 32'sd0, 32'sd5, 1'b1, '{ST_NOT_FOUND, 6'd0, 7'd0, 32'sd0}},
      '{REQ_UNUSED, 32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd0, 7'd0, 32'sd0}},
      '{REQ_APPEND, 32'sd0, WORD_MIN, 1'b1, '{ST_OK, 6'd0, 7'd1, WORD_MIN}},
      '{REQ_APPEND, 32'sd0, -32'sd1, 1'b1, '{ST_OK, 6'd1, 7'd2, WORD_MIN}},
      '{REQ_APPEND, 32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd2, 7'd3, WORD_MIN}},
      '{REQ_APPEND, 32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd3, 7'd4, WORD_MIN}},
      '{REQ_APPEND, 32'sd0, WORD_MAX, 1'b1, '{ST_OK, 6'd4, 7'd5, WORD_MIN}},
      '{REQ_REPLACE, WORD_MIN, WORD_MAX, 1'b0, NO_RESULT},
      '{REQ_REPLACE, 32'sd0, WORD_MIN, 1'b0, NO_RESULT},
      '{REQ_REPLACE, 32'sd12345, 32'sd1, 1'b0, NO_RESULT},
      '{REQ_REPLACE, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, NO_RESULT},
      '{REQ_CLEAR, 32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd0, 7'd0, 32'sd0}},
      '{REQ_APPEND, 32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd0, 7'd1, 32'sd0}},
      '{REQ_APPEND, 32'sd0, 32'sd5, 1'b1, '{ST_OK, 6'd1, 7'd2, 32'sd0}},
      '{REQ_APPEND, 32'sd0, 32'sd5, 1'b1, '{ST_OK, 6'd2, 7'd3, 32'sd0}},
      // equal children
      '{REQ_REPLACE, 32'sd0, 32'sd9, 1'b0, NO_RESULT},
      '{REQ_CLEAR, 32'sd0, 32'sd0, 1'b1, '{ST_OK, 6'd0, 7'd0, 32'sd0}},
      '{REQ_APPEND, 32'sd0, 32'sd1, 1'b0, NO_RESULT},
      '{REQ_APPEND, 32'sd0, 32'sd5, 1'b0, NO_RESULT},
      '{REQ_APPEND, 32'sd0, 32'sd9, 1'b0, NO_RESULT},
      '{REQ_APPEND, 32'sd0, 32'sd7, 1'b0, NO_RESULT},
      // slot 1 has a left child only
      '{REQ_REPLACE, 32'sd5, 32'sd8, 1'b0, NO_RESULT},
      '{REQ_REPLACE, 32'sd7, -32'sd5, 1'b0, NO_RESULT},
      '{REQ_UNUSED, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, NO_RESULT},
      '{REQ_CLEAR, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b1, '{ST_OK, 6'd0, 7'd0, 32'sd0}}
   };

   initial begin : req_side
      logic signed [31:0] run_vals [MHRV_DEPTH];
      logic signed [31:0] v;
      int n, extra, reps, mode, j, k, run_idx, pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         offer_request(directed_rows[r].kind, directed_rows[r].oldv, directed_rows[r].newv,
                       directed_rows[r].typed, directed_rows[r].want);
      wait_drained();

      run_idx = 0;
      while (items_sent < RANDOM_ITEMS + 25) begin
         mode = $urandom_range(0, 2);
         idle_off = ($urandom_range(0, 4) == 0);
         n = (run_idx == 0 || $urandom_range(0, 7) == 0) ? MHRV_DEPTH : $urandom_range(1, 20);
         extra = (n == MHRV_DEPTH) ? $urandom_range(1, 2) : 0;
         // ascending order loads a valid heap
         for (k = 0; k < n; k++) begin
            v = pick_value(mode);
            j = k;
            while (j > 0 && run_vals[j - 1] > v) begin
               run_vals[j] = run_vals[j - 1];
               j--;
            end
            run_vals[j] = v;
         end
         if (run_idx == 0 || $urandom_range(0, 5) != 0)
            offer_request(REQ_CLEAR, $urandom, $urandom, 1'b0, NO_RESULT);
         for (k = 0; k < n; k++)
            offer_request(REQ_APPEND, $urandom, run_vals[k], 1'b0, NO_RESULT);
         for (k = 0; k < extra; k++)
            offer_request(REQ_APPEND, $urandom, pick_value(mode), 1'b0, NO_RESULT);
         if (run_idx == 2) hold_req = 1'b1;
         reps = $urandom_range(2, 12);
         for (k = 0; k < reps; k++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               offer_request(REQ_UNUSED, $urandom, $urandom, 1'b0, NO_RESULT);
            else if (pick == 1 || heap_size == 0)
               offer_request(REQ_REPLACE, pick_value(mode), pick_value(mode), 1'b0, NO_RESULT);
            else if (pick == 2)
               offer_request(REQ_APPEND, $urandom, pick_value(mode), 1'b0, NO_RESULT);
            else
               offer_request(REQ_REPLACE, heap_mirror[$urandom_range(0, heap_size - 1)],
                             pick_value(mode), 1'b0, NO_RESULT);
         end
         if (run_idx == 1 || $urandom_range(0, 7) == 0) wait_drained();
         run_idx++;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("min_heap_replace_value test passed");
      else
         $display("min_heap_replace_value test failed");
      $finish;
   end

endmodule
